// ----- rtl/atm_pkg.sv -----
// Shared types and constants for the alarm time match table.
package atm_pkg;

  localparam int HOURS_W    = 5;
  localparam int MINUTES_W  = 6;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 2;
  localparam int COMMAND_W  = 2;

  localparam int MAX_HOURS   = 23;
  localparam int MAX_MINUTES = 59;

  // A list answer carries at most this many words.
  localparam int LIST_MAX    = 4;
  localparam int LIST_CNT_W  = $clog2(LIST_MAX);

  typedef enum logic [COMMAND_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_LIST  = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_INVALID = 3'd3,
    ST_HIT     = 3'd4,
    ST_NOMATCH = 3'd5,
    ST_LISTED  = 3'd6,
    ST_NONE    = 3'd7
  } status_t;

  // Controller -> datapath.
  typedef struct packed {
    logic load;     // take a new command word
    logic capture;  // register the result of this scan step, apply table update
    logic advance;  // move the scan index on by one slot
  } ctl_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic found;     // current scan step yields a result word
    logic held_last; // result word in the output register closes the answer
  } dp_status_t;

endpackage

// ----- rtl/atm_cmd_if.sv -----
// Command channel: valid/ready handshake carrying one command word.
interface atm_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [atm_pkg::COMMAND_W-1:0]  command;
  logic [atm_pkg::HOURS_W-1:0]    hours;
  logic [atm_pkg::MINUTES_W-1:0]  minutes;

  modport source (output valid, output command, output hours, output minutes, input ready);
  modport sink   (input valid, input command, input hours, input minutes, output ready);
endinterface

// ----- rtl/atm_res_if.sv -----
// Result channel: valid/ready handshake carrying one result word.
interface atm_res_if;
  logic                           valid;
  logic                           ready;
  logic [atm_pkg::STATUS_W-1:0]   status;
  logic [atm_pkg::SLOT_W-1:0]     slot;
  logic [atm_pkg::HOURS_W-1:0]    alarm_hours;
  logic [atm_pkg::MINUTES_W-1:0]  alarm_minutes;
  logic                           last;

  modport source (output valid, output status, output slot, output alarm_hours,
                  output alarm_minutes, output last, input ready);
  modport sink   (input valid, input status, input slot, input alarm_hours,
                  input alarm_minutes, input last, output ready);
endinterface

// ----- rtl/atm_ctrl.sv -----
// Sequencer: accept a command word, step the slot scan, hold each result word.
module atm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output atm_pkg::ctl_cmd_t   ctl,
  input  atm_pkg::dp_status_t dp
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    ctl         = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (dp.found) begin
          ctl.capture = 1'b1;
          state_next  = S_HOLD;
        end else begin
          ctl.advance = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_ready) begin
          if (dp.held_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.advance = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_HOLD);

  // A result word is only ever held right after a capture.
  a_hold_after_capture: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.capture))
    else $error("result held without capture");

  // The answer closes only on a word marked last.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && out_ready && !dp.held_last) |=> state == S_SCAN)
    else $error("answer closed before last word");

endmodule

// ----- rtl/atm_dp.sv -----
// Slot table, scan index and result register.
module atm_dp #(
  parameter int ALARM_SLOTS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  atm_pkg::ctl_cmd_t               ctl,
  output atm_pkg::dp_status_t             dp,
  input  logic [atm_pkg::COMMAND_W-1:0]   in_command,
  input  logic [atm_pkg::HOURS_W-1:0]     in_hours,
  input  logic [atm_pkg::MINUTES_W-1:0]   in_minutes,
  output logic [atm_pkg::STATUS_W-1:0]    out_status,
  output logic [atm_pkg::SLOT_W-1:0]      out_slot,
  output logic [atm_pkg::HOURS_W-1:0]     out_hours,
  output logic [atm_pkg::MINUTES_W-1:0]   out_minutes,
  output logic                            out_last
);

  localparam int CW = $clog2(ALARM_SLOTS + 1);
  localparam int IW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

  // Slot table; entries at or above used_count are never looked at.
  logic [atm_pkg::HOURS_W-1:0]   tbl_hours   [ALARM_SLOTS];
  logic [atm_pkg::MINUTES_W-1:0] tbl_minutes [ALARM_SLOTS];
  logic                          tbl_active  [ALARM_SLOTS];
  logic [CW-1:0]                 used_count;

  // Latched command word and scan state.
  atm_pkg::command_t             cmd_q;
  logic [atm_pkg::HOURS_W-1:0]   hours_q;
  logic [atm_pkg::MINUTES_W-1:0] minutes_q;
  logic [CW-1:0]                 idx;
  logic [atm_pkg::LIST_CNT_W-1:0] list_n;

  logic                          scan_end, cur_match, cur_act, more_active;
  logic                          table_full, bad_time, list_cap;
  logic [IW-1:0]                 ridx;

  logic                          res_found, res_last, add_ok, hit, listed;
  atm_pkg::status_t              res_status;
  logic [atm_pkg::SLOT_W-1:0]    res_slot;
  logic [atm_pkg::HOURS_W-1:0]   res_hours;
  logic [atm_pkg::MINUTES_W-1:0] res_minutes;

  assign scan_end   = (idx >= used_count);
  assign ridx       = scan_end ? '0 : idx[IW-1:0];
  assign cur_match  = (tbl_hours[ridx] == hours_q) && (tbl_minutes[ridx] == minutes_q);
  assign cur_act    = !scan_end && tbl_active[ridx];
  assign table_full = (used_count == CW'(ALARM_SLOTS));
  assign bad_time   = (hours_q > atm_pkg::HOURS_W'(atm_pkg::MAX_HOURS)) ||
                      (minutes_q > atm_pkg::MINUTES_W'(atm_pkg::MAX_MINUTES));
  assign list_cap   = (list_n == atm_pkg::LIST_CNT_W'(atm_pkg::LIST_MAX - 1));

  // Any active used slot past the current one decides the last flag of a list word.
  always_comb begin
    more_active = 1'b0;
    for (int j = 0; j < ALARM_SLOTS; j++) begin
      if ((CW'(j) > idx) && (CW'(j) < used_count) && tbl_active[j]) begin
        more_active = 1'b1;
      end
    end
  end

  always_comb begin
    res_found   = 1'b0;
    res_status  = atm_pkg::ST_INVALID;
    res_slot    = '0;
    res_hours   = '0;
    res_minutes = '0;
    res_last    = 1'b1;
    add_ok      = 1'b0;
    hit         = 1'b0;
    listed      = 1'b0;
    case (cmd_q)
      atm_pkg::CMD_ADD: begin
        if (table_full) begin
          res_found  = 1'b1;
          res_status = atm_pkg::ST_FULL;
        end else if (bad_time) begin
          res_found  = 1'b1;
          res_status = atm_pkg::ST_INVALID;
        end else if (scan_end) begin
          res_found  = 1'b1;
          res_status = atm_pkg::ST_ADDED;
          res_slot   = atm_pkg::SLOT_W'(idx);
          add_ok     = 1'b1;
        end else if (cur_match) begin
          res_found  = 1'b1;
          res_status = atm_pkg::ST_EXISTS;
        end
      end
      atm_pkg::CMD_CHECK: begin
        if (scan_end) begin
          res_found  = 1'b1;
          res_status = atm_pkg::ST_NOMATCH;
        end else if (cur_act && cur_match) begin
          res_found   = 1'b1;
          res_status  = atm_pkg::ST_HIT;
          res_slot    = atm_pkg::SLOT_W'(idx);
          res_hours   = hours_q;
          res_minutes = minutes_q;
          hit         = 1'b1;
        end
      end
      atm_pkg::CMD_LIST: begin
        // End of scan is only reached here when nothing was listed.
        if (scan_end) begin
          res_found  = 1'b1;
          res_status = atm_pkg::ST_NONE;
        end else if (cur_act) begin
          res_found   = 1'b1;
          res_status  = atm_pkg::ST_LISTED;
          res_slot    = atm_pkg::SLOT_W'(idx);
          res_hours   = tbl_hours[ridx];
          res_minutes = tbl_minutes[ridx];
          res_last    = list_cap || !more_active;
          listed      = 1'b1;
        end
      end
      default: begin
        res_found  = 1'b1;
        res_status = atm_pkg::ST_INVALID;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      idx        <= '0;
      list_n     <= '0;
    end else begin
      if (ctl.load) begin
        idx    <= '0;
        list_n <= '0;
      end else if (ctl.advance) begin
        idx <= idx + CW'(1);
      end
      if (ctl.capture && add_ok) begin
        used_count <= used_count + CW'(1);
      end
      if (ctl.capture && listed) begin
        list_n <= list_n + atm_pkg::LIST_CNT_W'(1);
      end
    end
  end

  // Payload: command latch, table, result register.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= atm_pkg::command_t'(in_command);
      hours_q   <= in_hours;
      minutes_q <= in_minutes;
    end
    if (ctl.capture) begin
      out_status  <= res_status;
      out_slot    <= res_slot;
      out_hours   <= res_hours;
      out_minutes <= res_minutes;
      out_last    <= res_last;
      if (add_ok) begin
        tbl_hours[used_count[IW-1:0]]   <= hours_q;
        tbl_minutes[used_count[IW-1:0]] <= minutes_q;
        tbl_active[used_count[IW-1:0]]  <= 1'b1;
      end
      if (hit) begin
        tbl_active[ridx] <= 1'b0;
      end
    end
  end

  assign dp.found     = res_found;
  assign dp.held_last = out_last;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(ALARM_SLOTS))
    else $error("used count past table size");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.capture && add_ok) |=> used_count == $past(used_count) + CW'(1))
    else $error("add did not take a slot");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (ctl.capture && res_status != atm_pkg::ST_LISTED) |-> res_last)
    else $error("single-word answer not marked last");

endmodule

// ----- rtl/alarm_time_match_table_unit.sv -----
// Top level of the alarm time match table: controller plus slot datapath.
// Keeps ALARM_SLOTS hour:minute alarm slots filled in order (the fill count never
// shrinks) and answers three commands: add (0), check (1) and list (2). One command
// word is in flight at a time; cmd.ready is high only while no answer is pending.
// The controller scans the table one slot per cycle while no result word is held,
// and each answer word is captured into the output register in the scan step that
// yields it; add on a full table or with an out-of-range time answers on the first
// scan step. Each result word waits in an output register until res.ready; a list
// answer resumes the scan after each word but the last is taken and gives up to four
// words, the final one with last set. Every other answer is one word with last set.
// Check clears the active flag of the first active slot that matches; add refuses any
// time already in a used slot, active or not. With res.ready high, a one-word command
// passes through the idle, scan and hold states in that order.
module alarm_time_match_table_unit #(
  parameter int ALARM_SLOTS = 4
) (
  input  logic clk,
  input  logic rst,
  atm_cmd_if.sink   cmd,
  atm_res_if.source res
);

  atm_pkg::ctl_cmd_t   ctl;
  atm_pkg::dp_status_t dp;

  atm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .ctl       (ctl),
    .dp        (dp)
  );

  atm_dp #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .dp          (dp),
    .in_command  (cmd.command),
    .in_hours    (cmd.hours),
    .in_minutes  (cmd.minutes),
    .out_status  (res.status),
    .out_slot    (res.slot),
    .out_hours   (res.alarm_hours),
    .out_minutes (res.alarm_minutes),
    .out_last    (res.last)
  );

  // Never take a new command word while an answer word is still offered.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && res.valid))
    else $error("command taken while result pending");

endmodule
